[hw/rtl/mcl_pkg.sv]
// Package for the Markov clustering engine: defaults, register indexes and item types.
`timescale 1ns / 1ps
package mcl_pkg;

  localparam int MAX_NODES_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPANSION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INFLATION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRUNE_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERGE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd5;

  localparam logic [4:0]  NODE_COUNT_RST = 5'd16;
  localparam logic [3:0]  EXPANSION_RST  = 4'd2;
  localparam logic [3:0]  INFLATION_RST  = 4'd2;
  localparam logic [31:0] PRUNE_THR_RST  = 32'd214748;
  localparam logic [31:0] CONVERGE_RST   = 32'd21;
  localparam logic [7:0]  MAX_ITER_RST   = 8'd100;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  column_index;
    logic [15:0] edge_weight;
    logic        entry_present;
    logic        last_entry;
  } mcl_in_t;

  typedef struct packed {
    logic [3:0] node_id;
    logic [3:0] cluster_label;
    logic       hit_iteration_limit;
    logic       last_label;
  } mcl_out_t;

endpackage

[hw/rtl/markov_cluster_engine_unit.sv]
// Markov clustering engine: entry loader, iterative clustering sequencer and label output.
// Load: one entry item per cycle; the item with last_entry starts clustering and in_stall
//   stays high until the last label is taken.
// Each iteration normalizes columns (restoring divider), compares with the previous matrix
//   (skipped on the first) and copies it, then expands by sq squarings and inflates to power p;
//   all steps share one read port per matrix RAM and the one 32x32 multiplier; sq = max(1, e-1).
// Labels: n result items, one per node; each stays on out_data while out_stall is high.
// Reset: synchronous, active low; clears control, registers to defaults and all present bits.
`timescale 1ns / 1ps
module markov_cluster_engine_unit #(
  parameter int MAX_NODES   = mcl_pkg::MAX_NODES_DEF,
  parameter int VALUE_WIDTH = mcl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mcl_pkg::mcl_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mcl_pkg::mcl_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [mcl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mcl_pkg::*;

  localparam int VW   = VALUE_WIDTH;
  localparam int FRAC = VW - 1;
  localparam int NW   = $clog2(MAX_NODES);
  localparam int NCW  = NW + 1;
  localparam int AW   = 2 * NW;
  localparam int CD   = 1 << AW;
  localparam int SW   = VW + NW;
  localparam int DW   = VW + FRAC;
  localparam int DCW  = $clog2(DW);
  localparam int CNW  = 2 * NW + 1;
  localparam int ACW  = VW + NW + 1;
  localparam int CW   = (NCW > 5) ? NCW : 5;
  localparam int EW   = (NCW > 4) ? NCW : 4;
  localparam logic [63:0] VMAX64 = 64'((65'd1 << VW) - 65'd1);

  typedef enum logic [28:0] {
    S_IDLE     = 29'b1 << 0,
    S_DIAG     = 29'b1 << 1,
    S_NSUM_RD  = 29'b1 << 2,
    S_NSUM_ACC = 29'b1 << 3,
    S_NDIV_RD  = 29'b1 << 4,
    S_NDIV_CHK = 29'b1 << 5,
    S_NDIV_RUN = 29'b1 << 6,
    S_CMP_RD   = 29'b1 << 7,
    S_CMP_MUL  = 29'b1 << 8,
    S_CMP_ACC  = 29'b1 << 9,
    S_CMP_THR  = 29'b1 << 10,
    S_CMP_TEST = 29'b1 << 11,
    S_COPY_RD  = 29'b1 << 12,
    S_COPY_WR  = 29'b1 << 13,
    S_SQ_RA    = 29'b1 << 14,
    S_SQ_RB    = 29'b1 << 15,
    S_SQ_MUL   = 29'b1 << 16,
    S_SQ_ACC   = 29'b1 << 17,
    S_SQ_WR    = 29'b1 << 18,
    S_SCP_RD   = 29'b1 << 19,
    S_SCP_WR   = 29'b1 << 20,
    S_INF_RD   = 29'b1 << 21,
    S_INF_LD   = 29'b1 << 22,
    S_INF_MUL  = 29'b1 << 23,
    S_INF_STEP = 29'b1 << 24,
    S_INF_WR   = 29'b1 << 25,
    S_LAB_RD   = 29'b1 << 26,
    S_LAB_CHK  = 29'b1 << 27,
    S_OUT      = 29'b1 << 28
  } state_t;

  // configuration
  logic [4:0]  node_count_r, node_count_nxt;
  logic [3:0]  exp_r, exp_nxt;
  logic [3:0]  pow_r, pow_nxt;
  logic [31:0] prune_r, prune_nxt;
  logic [31:0] conv_r, conv_nxt;
  logic [7:0]  max_iter_r, max_iter_nxt;

  state_t state_r, state_nxt;
  logic [NW-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [SW:0]    rem_r, rem_nxt;
  logic [DW-1:0]  dvd_r, dvd_nxt;
  logic [VW-1:0]  q_r, q_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [63:0]    sum_r, sum_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [ACW-1:0] acc_r, acc_nxt;
  logic           pp_r, pp_nxt;
  logic [3:0]     sq_cnt_r, sq_cnt_nxt;
  logic [31:0]    opa_r, opa_nxt;
  logic [VW-1:0]  v_r, v_nxt;
  logic [VW-1:0]  res_r, res_nxt;
  logic [3:0]     pc_r, pc_nxt;
  logic [8:0]     iter_r, iter_nxt;
  logic           limit_r, limit_nxt;
  logic           found_r, found_nxt;
  logic [VW-1:0]  best_r, best_nxt;
  logic [NW-1:0]  label_r, label_nxt;
  logic [CD-1:0]  cur_p_r, cur_p_nxt;
  logic [CD-1:0]  prev_p_r, prev_p_nxt;
  logic [CD-1:0]  scr_p_r, scr_p_nxt;
  logic           out_valid_r, out_valid_nxt;
  mcl_out_t       out_data_r, out_data_nxt;
  logic [63:0]    prod_r, prod_nxt;

  // matrix RAMs
  logic [VW-1:0] cm_mem [CD];
  logic [VW-1:0] pm_mem [CD];
  logic [VW-1:0] sm_mem [CD];
  logic          cm_we, pm_we, sm_we;
  logic [AW-1:0] cm_waddr, pm_waddr, sm_waddr;
  logic [VW-1:0] cm_wdata, pm_wdata, sm_wdata;
  logic [AW-1:0] cm_raddr, pm_raddr, sm_raddr;
  logic [VW-1:0] cm_rdata_r, pm_rdata_r, sm_rdata_r;

  // shared helpers
  logic [31:0]    mul_a, mul_b;
  logic [CW-1:0]  ncx;
  logic [NCW-1:0] n_cur;
  logic           i_last, j_last, k_last;
  logic [NW-1:0]  cj_nxt, ci_nxt;
  logic           cell_done;
  logic [AW-1:0]  c_ij;
  logic [EW-1:0]  row_x, col_x;
  logic           ld_inb;
  logic [AW-1:0]  ld_addr;
  logic [63:0]    q_full;
  logic [VW-1:0]  qsat;
  logic [SW:0]    rem_sh;
  logic           div_ge;
  logic [VW-1:0]  cmp_a, cmp_b, cmp_df;
  logic [3:0]     sq_tot;
  logic           lab_upd;
  logic [NW-1:0]  lab_sel;

  assign ncx   = CW'(node_count_r);
  assign n_cur = (ncx == '0) ? NCW'(1) :
                 (ncx > CW'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(ncx);

  assign i_last    = (NCW'(i_r) == n_cur - NCW'(1));
  assign j_last    = (NCW'(j_r) == n_cur - NCW'(1));
  assign k_last    = (NCW'(k_r) == n_cur - NCW'(1));
  assign cj_nxt    = j_last ? '0 : j_r + 1'b1;
  assign ci_nxt    = j_last ? (i_last ? '0 : i_r + 1'b1) : i_r;
  assign cell_done = i_last & j_last;
  assign c_ij      = {i_r, j_r};

  assign row_x   = EW'(in_data.row_index);
  assign col_x   = EW'(in_data.column_index);
  assign ld_inb  = (row_x < EW'(n_cur)) && (col_x < EW'(n_cur));
  assign ld_addr = {row_x[NW-1:0], col_x[NW-1:0]};

  assign prod_nxt = mul_a * mul_b;
  assign q_full   = prod_r >> FRAC;
  assign qsat     = (q_full > VMAX64) ? {VW{1'b1}} : q_full[VW-1:0];

  // restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem_r[SW-1:0], dvd_r[DW-1]};
  assign div_ge = (rem_sh >= {1'b0, s_r});

  assign cmp_a  = cur_p_r[c_ij] ? cm_rdata_r : '0;
  assign cmp_b  = prev_p_r[c_ij] ? pm_rdata_r : '0;
  assign cmp_df = (cmp_a > cmp_b) ? (cmp_a - cmp_b) : (cmp_b - cmp_a);

  assign sq_tot = (exp_r < 4'd2) ? 4'd1 : exp_r - 4'd1;

  assign lab_upd = cur_p_r[c_ij] && (!found_r || (cm_rdata_r > best_r));
  assign lab_sel = lab_upd ? i_r : label_r;

  always_comb begin
    node_count_nxt = node_count_r;
    exp_nxt        = exp_r;
    pow_nxt        = pow_r;
    prune_nxt      = prune_r;
    conv_nxt       = conv_r;
    max_iter_nxt   = max_iter_r;
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    s_nxt          = s_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    q_nxt          = q_r;
    dcnt_nxt       = dcnt_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    pp_nxt         = pp_r;
    sq_cnt_nxt     = sq_cnt_r;
    opa_nxt        = opa_r;
    v_nxt          = v_r;
    res_nxt        = res_r;
    pc_nxt         = pc_r;
    iter_nxt       = iter_r;
    limit_nxt      = limit_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    label_nxt      = label_r;
    cur_p_nxt      = cur_p_r;
    prev_p_nxt     = prev_p_r;
    scr_p_nxt      = scr_p_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    cm_we          = 1'b0;
    cm_waddr       = c_ij;
    cm_wdata       = '0;
    pm_we          = 1'b0;
    pm_waddr       = c_ij;
    pm_wdata       = '0;
    sm_we          = 1'b0;
    sm_waddr       = c_ij;
    sm_wdata       = '0;
    cm_raddr       = c_ij;
    pm_raddr       = c_ij;
    sm_raddr       = c_ij;
    mul_a          = opa_r;
    mul_b          = 32'(v_r);

    if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count_nxt = cfg_wdata[4:0];
        REG_EXPANSION:  exp_nxt        = cfg_wdata[3:0];
        REG_INFLATION:  pow_nxt        = cfg_wdata[3:0];
        REG_PRUNE_THR:  prune_nxt      = cfg_wdata;
        REG_CONVERGE:   conv_nxt       = cfg_wdata;
        REG_MAX_ITER:   max_iter_nxt   = cfg_wdata[7:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.entry_present && ld_inb) begin
            cm_we              = 1'b1;
            cm_waddr           = ld_addr;
            cm_wdata           = VW'(in_data.edge_weight);
            cur_p_nxt[ld_addr] = 1'b1;
          end
          if (in_data.last_entry) begin
            i_nxt     = '0;
            state_nxt = S_DIAG;
          end
        end
      end
      S_DIAG: begin
        // unit self-loop where the diagonal is absent
        if (!cur_p_r[{i_r, i_r}]) begin
          cur_p_nxt[{i_r, i_r}] = 1'b1;
          cm_we    = 1'b1;
          cm_waddr = {i_r, i_r};
          cm_wdata = VW'(1);
        end
        if (i_last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          s_nxt     = '0;
          iter_nxt  = '0;
          state_nxt = S_NSUM_RD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_NSUM_RD: state_nxt = S_NSUM_ACC;
      S_NSUM_ACC: begin
        if (cur_p_r[c_ij]) s_nxt = s_r + SW'(cm_rdata_r);
        if (i_last) begin
          i_nxt     = '0;
          state_nxt = S_NDIV_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_NSUM_RD;
        end
      end
      S_NDIV_RD: state_nxt = S_NDIV_CHK;
      S_NDIV_CHK, S_NDIV_RUN: begin
        logic adv;
        adv = 1'b0;
        if (state_r == S_NDIV_CHK) begin
          if (s_r == '0) begin
            cur_p_nxt[c_ij] = 1'b0;
            adv = 1'b1;
          end else if (cur_p_r[c_ij]) begin
            dvd_nxt   = {cm_rdata_r, {FRAC{1'b0}}};
            rem_nxt   = '0;
            q_nxt     = '0;
            dcnt_nxt  = '0;
            state_nxt = S_NDIV_RUN;
          end else begin
            adv = 1'b1;
          end
        end else begin
          rem_nxt  = div_ge ? (rem_sh - {1'b0, s_r}) : rem_sh;
          q_nxt    = {q_r[VW-2:0], div_ge};
          dvd_nxt  = dvd_r << 1;
          dcnt_nxt = dcnt_r + 1'b1;
          if (dcnt_r == DCW'(DW - 1)) begin
            cm_we    = 1'b1;
            cm_wdata = {q_r[VW-2:0], div_ge};
            adv      = 1'b1;
          end
        end
        if (adv) begin
          if (i_last) begin
            i_nxt = '0;
            if (j_last) begin
              j_nxt   = '0;
              sum_nxt = '0;
              cnt_nxt = '0;
              state_nxt = (iter_r == '0) ? S_COPY_RD : S_CMP_RD;
            end else begin
              j_nxt     = j_r + 1'b1;
              s_nxt     = '0;
              state_nxt = S_NSUM_RD;
            end
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_NDIV_RD;
          end
        end
      end
      S_CMP_RD: state_nxt = S_CMP_MUL;
      S_CMP_MUL: begin
        mul_a = 32'(cmp_df);
        mul_b = 32'(cmp_df);
        if (cur_p_r[c_ij] || prev_p_r[c_ij]) begin
          state_nxt = S_CMP_ACC;
        end else begin
          i_nxt     = ci_nxt;
          j_nxt     = cj_nxt;
          state_nxt = cell_done ? S_CMP_THR : S_CMP_RD;
        end
      end
      S_CMP_ACC: begin
        sum_nxt   = sum_r + q_full;
        cnt_nxt   = cnt_r + 1'b1;
        i_nxt     = ci_nxt;
        j_nxt     = cj_nxt;
        state_nxt = cell_done ? S_CMP_THR : S_CMP_RD;
      end
      S_CMP_THR: begin
        mul_a     = conv_r;
        mul_b     = 32'(cnt_r);
        state_nxt = S_CMP_TEST;
      end
      S_CMP_TEST: begin
        i_nxt     = '0;
        j_nxt     = '0;
        found_nxt = 1'b0;
        label_nxt = '0;
        if (sum_r < prod_r) begin
          limit_nxt = 1'b0;
          state_nxt = S_LAB_RD;
        end else if (iter_r > 9'(max_iter_r)) begin
          limit_nxt = 1'b1;
          state_nxt = S_LAB_RD;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_COPY_RD: state_nxt = S_COPY_WR;
      S_COPY_WR: begin
        pm_we            = 1'b1;
        pm_wdata         = cm_rdata_r;
        prev_p_nxt[c_ij] = cur_p_r[c_ij];
        i_nxt            = ci_nxt;
        j_nxt            = cj_nxt;
        if (cell_done) begin
          sq_cnt_nxt = '0;
          k_nxt      = '0;
          acc_nxt    = '0;
          pp_nxt     = 1'b0;
          state_nxt  = S_SQ_RA;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_SQ_RA: begin
        cm_raddr  = {i_r, k_r};
        state_nxt = S_SQ_RB;
      end
      S_SQ_RB: begin
        opa_nxt   = 32'(cm_rdata_r);
        cm_raddr  = {k_r, j_r};
        state_nxt = S_SQ_MUL;
      end
      S_SQ_MUL, S_SQ_ACC: begin
        mul_a = opa_r;
        mul_b = 32'(cm_rdata_r);
        if (state_r == S_SQ_MUL && cur_p_r[{i_r, k_r}] && cur_p_r[{k_r, j_r}]) begin
          pp_nxt    = 1'b1;
          state_nxt = S_SQ_ACC;
        end else begin
          if (state_r == S_SQ_ACC) acc_nxt = acc_r + ACW'(qsat);
          if (k_last) begin
            k_nxt     = '0;
            state_nxt = S_SQ_WR;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_SQ_RA;
          end
        end
      end
      S_SQ_WR: begin
        sm_we           = 1'b1;
        sm_wdata        = !pp_r ? '0 :
                          (acc_r > ACW'(VMAX64)) ? {VW{1'b1}} : acc_r[VW-1:0];
        scr_p_nxt[c_ij] = pp_r;
        acc_nxt         = '0;
        pp_nxt          = 1'b0;
        i_nxt           = ci_nxt;
        j_nxt           = cj_nxt;
        state_nxt       = cell_done ? S_SCP_RD : S_SQ_RA;
      end
      S_SCP_RD: state_nxt = S_SCP_WR;
      S_SCP_WR: begin
        cm_we           = 1'b1;
        cm_wdata        = sm_rdata_r;
        cur_p_nxt[c_ij] = scr_p_r[c_ij];
        i_nxt           = ci_nxt;
        j_nxt           = cj_nxt;
        if (cell_done) begin
          sq_cnt_nxt = sq_cnt_r + 1'b1;
          if (sq_cnt_r + 4'd1 >= sq_tot) begin
            state_nxt = S_INF_RD;
          end else begin
            k_nxt     = '0;
            state_nxt = S_SQ_RA;
          end
        end else begin
          state_nxt = S_SCP_RD;
        end
      end
      S_INF_RD: state_nxt = S_INF_LD;
      S_INF_LD: begin
        if (!cur_p_r[c_ij]) begin
          i_nxt = ci_nxt;
          j_nxt = cj_nxt;
          if (cell_done) begin
            iter_nxt  = iter_r + 1'b1;
            s_nxt     = '0;
            state_nxt = S_NSUM_RD;
          end else begin
            state_nxt = S_INF_RD;
          end
        end else begin
          v_nxt = cm_rdata_r;
          if (pow_r == 4'd0) begin
            res_nxt   = {1'b1, {FRAC{1'b0}}};
            state_nxt = S_INF_WR;
          end else begin
            res_nxt   = cm_rdata_r;
            pc_nxt    = 4'd1;
            state_nxt = (pow_r == 4'd1) ? S_INF_WR : S_INF_MUL;
          end
        end
      end
      S_INF_MUL: begin
        mul_a     = 32'(res_r);
        mul_b     = 32'(v_r);
        state_nxt = S_INF_STEP;
      end
      S_INF_STEP: begin
        res_nxt   = qsat;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = (pc_r + 4'd1 == pow_r) ? S_INF_WR : S_INF_MUL;
      end
      S_INF_WR: begin
        if (32'(res_r) <= prune_r) begin
          cur_p_nxt[c_ij] = 1'b0;
        end else begin
          cm_we    = 1'b1;
          cm_wdata = res_r;
        end
        i_nxt = ci_nxt;
        j_nxt = cj_nxt;
        if (cell_done) begin
          iter_nxt  = iter_r + 1'b1;
          s_nxt     = '0;
          state_nxt = S_NSUM_RD;
        end else begin
          state_nxt = S_INF_RD;
        end
      end
      S_LAB_RD: state_nxt = S_LAB_CHK;
      S_LAB_CHK: begin
        if (lab_upd) begin
          found_nxt = 1'b1;
          best_nxt  = cm_rdata_r;
        end
        label_nxt = lab_sel;
        if (i_last) begin
          out_valid_nxt                    = 1'b1;
          out_data_nxt.node_id             = 4'(j_r);
          out_data_nxt.cluster_label       = found_r || lab_upd ? 4'(lab_sel) : 4'(j_r);
          out_data_nxt.hit_iteration_limit = limit_r;
          out_data_nxt.last_label          = j_last;
          state_nxt                        = S_OUT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_LAB_RD;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          i_nxt         = '0;
          found_nxt     = 1'b0;
          if (j_last) begin
            // job done: drop the whole store
            cur_p_nxt  = '0;
            prev_p_nxt = '0;
            scr_p_nxt  = '0;
            iter_nxt   = '0;
            j_nxt      = '0;
            state_nxt  = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_LAB_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      exp_r        <= EXPANSION_RST;
      pow_r        <= INFLATION_RST;
      prune_r      <= PRUNE_THR_RST;
      conv_r       <= CONVERGE_RST;
      max_iter_r   <= MAX_ITER_RST;
      state_r      <= S_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
      sq_cnt_r     <= '0;
      pc_r         <= '0;
      dcnt_r       <= '0;
      iter_r       <= '0;
      limit_r      <= 1'b0;
      found_r      <= 1'b0;
      pp_r         <= 1'b0;
      cur_p_r      <= '0;
      prev_p_r     <= '0;
      scr_p_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      exp_r        <= exp_nxt;
      pow_r        <= pow_nxt;
      prune_r      <= prune_nxt;
      conv_r       <= conv_nxt;
      max_iter_r   <= max_iter_nxt;
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      k_r          <= k_nxt;
      sq_cnt_r     <= sq_cnt_nxt;
      pc_r         <= pc_nxt;
      dcnt_r       <= dcnt_nxt;
      iter_r       <= iter_nxt;
      limit_r      <= limit_nxt;
      found_r      <= found_nxt;
      pp_r         <= pp_nxt;
      cur_p_r      <= cur_p_nxt;
      prev_p_r     <= prev_p_nxt;
      scr_p_r      <= scr_p_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    opa_r      <= opa_nxt;
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    best_r     <= best_nxt;
    label_r    <= label_nxt;
    out_data_r <= out_data_nxt;
    prod_r     <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (cm_we) cm_mem[cm_waddr] <= cm_wdata;
    cm_rdata_r <= cm_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    pm_rdata_r <= pm_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
    sm_rdata_r <= sm_mem[sm_raddr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> in_stall)
    else $error("result item shown while input side open");

  a_last_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_entry) |=> in_stall)
    else $error("last entry did not start clustering");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NDIV_RUN) |-> (s_r != '0))
    else $error("divide by zero column sum");

  a_job_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_label) |=> (!in_stall && cur_p_r == '0))
    else $error("store not cleared after final label");

endmodule
